### rtl/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and constants for the speed, rpm and gear estimator.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam int unsigned UsecPerSec = 1000000;
    localparam int unsigned SpeedMax   = 262143;
    localparam int unsigned RpmMax     = 65535;
    localparam int unsigned RatioMax   = 65535;

    // command codes
    typedef enum logic [1:0] {
        CMD_SPEED   = 2'd0,
        CMD_TACH    = 2'd1,
        CMD_NEUTRAL = 2'd2,
        CMD_REPORT  = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED_SCALE = 3'd0;
    localparam logic [2:0] REG_REV_SCALE   = 3'd1;
    localparam logic [2:0] REG_SPEED_MIN   = 3'd2;
    localparam logic [2:0] REG_REV_MIN     = 3'd3;
    localparam logic [2:0] REG_BOUND_ONE   = 3'd4;
    localparam logic [2:0] REG_BOUND_TWO   = 3'd5;
    localparam logic [2:0] REG_BOUND_THREE = 3'd6;
    localparam logic [2:0] REG_BOUND_FOUR  = 3'd7;

    // report job handed from front to back
    typedef struct packed {
        logic [31:0] speed_period;
        logic [31:0] rev_period;
        logic        neutral;
    } t_job;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED,
        ST_REV,
        ST_RATIO,
        ST_GEAR,
        ST_OUT
    } t_state;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [55:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

### rtl/speed_rpm_gear_estimator.sv
// ----------------------------------------------------------------------------
// speed_rpm_gear_estimator
// Gear estimate from road-speed and engine-speed pulse periods.
// ----------------------------------------------------------------------------
// Edge and neutral transactions are always accepted unless the job queue is
// full. A report transaction queues a snapshot of the periods; the back end
// then runs up to three 56-step divisions on one shared bit-serial divider,
// skipping a division when a period or the rpm is zero. Up to four reports may
// wait in the queue; while it is full, no transaction is accepted.
module speed_rpm_gear_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_time_us,
    input  logic        i_neutral_pin,
    output logic        empty,
    input  logic        pop,
    output logic [17:0] o_speed_mph,
    output logic [15:0] o_rev_rpm,
    output logic [15:0] o_ratio_q8,
    output logic [2:0]  o_gear,
    output logic        o_top_gear_lamp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    logic [15:0] r_speed_scale, r_rev_scale, r_b1, r_b2, r_b3, r_b4;
    logic [19:0] r_speed_min, r_rev_min;
    logic          q_full, job_push, job_pop, job_valid, busy, acc;
    sre_pkg::t_job job_in, job_out;

    assign full = busy;
    assign acc  = push && !full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale <= 16'd135;
            r_rev_scale   <= 16'd30;
            r_speed_min   <= 20'd700;
            r_rev_min     <= 20'd2200;
            r_b1          <= 16'd1615;
            r_b2          <= 16'd2248;
            r_b3          <= 16'd2852;
            r_b4          <= 16'd3394;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sre_pkg::REG_SPEED_SCALE: r_speed_scale <= i_cfg_data[15:0];
                sre_pkg::REG_REV_SCALE:   r_rev_scale   <= i_cfg_data[15:0];
                sre_pkg::REG_SPEED_MIN:   r_speed_min   <= i_cfg_data;
                sre_pkg::REG_REV_MIN:     r_rev_min     <= i_cfg_data;
                sre_pkg::REG_BOUND_ONE:   r_b1          <= i_cfg_data[15:0];
                sre_pkg::REG_BOUND_TWO:   r_b2          <= i_cfg_data[15:0];
                sre_pkg::REG_BOUND_THREE: r_b3          <= i_cfg_data[15:0];
                sre_pkg::REG_BOUND_FOUR:  r_b4          <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sre_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_command(i_command),
        .i_time_us(i_time_us), .i_neutral_pin(i_neutral_pin),
        .i_speed_min(r_speed_min), .i_rev_min(r_rev_min), .i_q_full(q_full),
        .o_busy(busy), .o_job_push(job_push), .o_job(job_in)
    );

    sre_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_push), .i_data(job_in),
        .o_full(q_full), .i_pop(job_pop), .o_valid(job_valid), .o_data(job_out)
    );

    sre_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job_out),
        .o_job_pop(job_pop), .i_speed_scale(r_speed_scale), .i_rev_scale(r_rev_scale),
        .i_bound_one(r_b1), .i_bound_two(r_b2), .i_bound_three(r_b3),
        .i_bound_four(r_b4), .i_pop(pop), .o_empty(empty),
        .o_speed_mph(o_speed_mph), .o_rev_rpm(o_rev_rpm), .o_ratio_q8(o_ratio_q8),
        .o_gear(o_gear), .o_top_gear_lamp(o_top_gear_lamp)
    );

`ifndef SYNTHESIS
    // lamp only in top gear
    a_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_top_gear_lamp == (o_gear == 3'd5))) else $error("lamp mismatch");
    // result holds while not taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_ratio_q8))) else $error("result lost");
    // zero rpm gives zero ratio
    a_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rev_rpm == 16'd0) |-> (o_ratio_q8 == 16'd0)) else $error("ratio");
`endif
endmodule

### rtl/sre_front.sv
// ----------------------------------------------------------------------------
// sre_front
// Edge qualification and neutral latch; queues report jobs.
// ----------------------------------------------------------------------------
module sre_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_command,
    input  logic [31:0]          i_time_us,
    input  logic                 i_neutral_pin,
    input  logic [19:0]          i_speed_min,
    input  logic [19:0]          i_rev_min,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_job_push,
    output sre_pkg::t_job        o_job
);
    logic [31:0] r_speed_last, r_speed_period, r_rev_last, r_rev_period;
    logic        r_neutral;
    logic [31:0] speed_gap, rev_gap;
    logic        is_speed, is_rev, is_neu, is_rep;

    assign is_speed = i_valid && (i_command == sre_pkg::CMD_SPEED);
    assign is_rev   = i_valid && (i_command == sre_pkg::CMD_TACH);
    assign is_neu   = i_valid && (i_command == sre_pkg::CMD_NEUTRAL);
    assign is_rep   = i_valid && (i_command == sre_pkg::CMD_REPORT);

    assign speed_gap = i_time_us - r_speed_last;
    assign rev_gap   = i_time_us - r_rev_last;

    // the front is busy, holding off all transactions, only when the queue is full
    assign o_busy     = i_q_full;
    assign o_job_push = is_rep;
    assign o_job      = '{speed_period: r_speed_period, rev_period: r_rev_period,
                          neutral: r_neutral};

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_last   <= '0;
            r_speed_period <= '0;
            r_rev_last     <= '0;
            r_rev_period   <= '0;
            r_neutral      <= 1'b0;
        end else begin
            if (is_speed && (speed_gap > {12'd0, i_speed_min})) begin
                r_speed_period <= speed_gap;
                r_speed_last   <= i_time_us;
            end
            if (is_rev && (rev_gap > {12'd0, i_rev_min})) begin
                r_rev_period <= rev_gap;
                r_rev_last   <= i_time_us;
            end
            if (is_neu) begin
                r_neutral <= ~i_neutral_pin;
            end
        end
    end
endmodule

### rtl/sre_div.sv
// ----------------------------------------------------------------------------
// sre_div
// Radix-2 restoring divider, 56-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module sre_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sre_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic [55:0]        o_quot
);
    logic [55:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_run, r_done;
    logic [32:0] shifted, diff;

    assign shifted = {r_rem[31:0], r_quot[55]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd55;
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.num;
            r_rem  <= '0;
            r_den  <= i_req.den;
        end else if (r_run) begin
            if (!diff[32]) begin
                r_rem  <= diff;
                r_quot <= {r_quot[54:0], 1'b1};
            end else begin
                r_rem  <= shifted;
                r_quot <= {r_quot[54:0], 1'b0};
            end
        end
    end
endmodule

### rtl/sre_back.sv
// ----------------------------------------------------------------------------
// sre_back
// Report sequencer: speed, rpm and ratio through one shared divider, then gear.
// ----------------------------------------------------------------------------
module sre_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sre_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic [15:0]        i_speed_scale,
    input  logic [15:0]        i_rev_scale,
    input  logic [15:0]        i_bound_one,
    input  logic [15:0]        i_bound_two,
    input  logic [15:0]        i_bound_three,
    input  logic [15:0]        i_bound_four,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [17:0]        o_speed_mph,
    output logic [15:0]        o_rev_rpm,
    output logic [15:0]        o_ratio_q8,
    output logic [2:0]         o_gear,
    output logic               o_top_gear_lamp
);
    sre_pkg::t_state   r_state, n_state;
    sre_pkg::t_job     r_job;
    sre_pkg::t_div_req div_req;
    logic              r_started;
    logic              div_done;
    logic [55:0]       div_quot;
    logic [17:0]       r_speed;
    logic [15:0]       r_rpm, r_ratio;
    logic [2:0]        r_gear, gear_c;
    logic              r_full;
    logic [35:0]       speed_num, rev_num;
    logic [17:0]       r_res_speed;
    logic [15:0]       r_res_rpm, r_res_ratio;
    logic [2:0]        r_res_gear;

    assign speed_num = 36'(sre_pkg::UsecPerSec) * {20'd0, i_speed_scale};
    assign rev_num   = 36'(sre_pkg::UsecPerSec) * {20'd0, i_rev_scale};

    sre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sre_pkg::ST_IDLE:  if (i_job_valid) n_state = sre_pkg::ST_SPEED;
            sre_pkg::ST_SPEED: if (div_done || (r_started && r_job.speed_period == '0))
                                   n_state = sre_pkg::ST_REV;
            sre_pkg::ST_REV:   if (div_done || (r_started && r_job.rev_period == '0))
                                   n_state = sre_pkg::ST_RATIO;
            sre_pkg::ST_RATIO: if (div_done || (r_started && r_rpm == '0))
                                   n_state = sre_pkg::ST_GEAR;
            sre_pkg::ST_GEAR:  if (!r_full) n_state = sre_pkg::ST_OUT;
            sre_pkg::ST_OUT:   n_state = sre_pkg::ST_IDLE;
            default:           n_state = sre_pkg::ST_IDLE;
        endcase
    end

    // divider requests and job pop
    always_comb begin
        div_req   = '{start: 1'b0, num: '0, den: '0};
        o_job_pop = 1'b0;
        unique case (r_state)
            sre_pkg::ST_IDLE:  o_job_pop = i_job_valid;
            sre_pkg::ST_SPEED: begin
                div_req.start = !r_started && (r_job.speed_period != '0);
                div_req.num   = {20'd0, speed_num};
                div_req.den   = r_job.speed_period;
            end
            sre_pkg::ST_REV: begin
                div_req.start = !r_started && (r_job.rev_period != '0);
                div_req.num   = {20'd0, rev_num};
                div_req.den   = r_job.rev_period;
            end
            sre_pkg::ST_RATIO: begin
                div_req.start = !r_started && (r_rpm != '0);
                div_req.num   = {30'd0, r_speed, 8'd0};
                div_req.den   = {16'd0, r_rpm};
            end
            default: ;
        endcase
    end

    // gear selection on the finished ratio
    always_comb begin
        priority if (r_job.neutral)          gear_c = 3'd0;
        else if (r_ratio < i_bound_one)      gear_c = 3'd1;
        else if (r_ratio < i_bound_two)      gear_c = 3'd2;
        else if (r_ratio < i_bound_three)    gear_c = 3'd3;
        else if (r_ratio < i_bound_four)     gear_c = 3'd4;
        else                                 gear_c = 3'd5;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sre_pkg::ST_IDLE;
            r_started <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_started <= 1'b0;
            else if (div_req.start) r_started <= 1'b1;
            else if (r_state != sre_pkg::ST_IDLE) r_started <= 1'b1;
            if (r_state == sre_pkg::ST_OUT) r_full <= 1'b1;
            else if (i_pop && r_full)       r_full <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == sre_pkg::ST_IDLE && i_job_valid) begin
            r_job   <= i_job;
            r_speed <= '0;
            r_rpm   <= '0;
            r_ratio <= '0;
        end
        if (div_done) begin
            unique case (r_state)
                sre_pkg::ST_SPEED:
                    r_speed <= (div_quot > 56'(sre_pkg::SpeedMax)) ? 18'h3FFFF
                                                                   : div_quot[17:0];
                sre_pkg::ST_REV:
                    r_rpm <= (div_quot > 56'(sre_pkg::RpmMax)) ? 16'hFFFF : div_quot[15:0];
                sre_pkg::ST_RATIO:
                    r_ratio <= (div_quot > 56'(sre_pkg::RatioMax)) ? 16'hFFFF
                                                                   : div_quot[15:0];
                default: ;
            endcase
        end
        if (r_state == sre_pkg::ST_GEAR) r_gear <= gear_c;
    end

    // result held apart from the working registers while it waits
    always_ff @(posedge i_clk) begin
        if (r_state == sre_pkg::ST_OUT) begin
            r_res_speed <= r_speed;
            r_res_rpm   <= r_rpm;
            r_res_ratio <= r_ratio;
            r_res_gear  <= r_gear;
        end
    end

    assign o_empty         = !r_full;
    assign o_speed_mph     = r_res_speed;
    assign o_rev_rpm       = r_res_rpm;
    assign o_ratio_q8      = r_res_ratio;
    assign o_gear          = r_res_gear;
    assign o_top_gear_lamp = (r_res_gear == 3'd5);
endmodule

### rtl/sre_fifo.sv
// ----------------------------------------------------------------------------
// sre_fifo
// Four-entry queue of report jobs between front and back.
// ----------------------------------------------------------------------------
module sre_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sre_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sre_pkg::t_job  o_data
);
    sre_pkg::t_job r_mem [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, i_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
